FILE: src/sdpp_pkg.sv
// Shared constants, codes and types for the minimum-distance point placement block.
package sdpp_pkg;

    localparam int COORD_BITS    = 16;
    localparam int COORD_W       = 16;
    localparam int MAX_CELLS_DEF = 1024;
    localparam int DIST_W        = 17;
    localparam int REJ_W         = 20;
    localparam int CELLS_W       = 11;
    localparam int STATUS_W      = 3;
    localparam int CIDX_W        = 10;
    localparam int NIDX_W        = 11;
    localparam int DSQ_W         = 33;
    localparam int PROD_W        = 2 * COORD_W;

    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 20;

    localparam int IN_DATA_W     = 56;
    localparam int OUT_FIELDS_W  = CIDX_W + 2 * COORD_W + DIST_W + REJ_W + NIDX_W + DSQ_W;
    localparam int OUT_DATA_W    = 128;
    localparam int OUT_PAD_W     = OUT_DATA_W - OUT_FIELDS_W;

    localparam logic [DSQ_W-1:0] COORD_MAX = DSQ_W'((64'd1 << COORD_BITS) - 64'd1);
    localparam logic [DSQ_W-1:0] EMPTY_DSQ = (COORD_MAX * COORD_MAX) << 1;
    localparam logic [REJ_W-1:0] REJ_MAX   = '1;

    localparam logic [1:0] MODE_LATCH = 2'd0;
    localparam logic [1:0] MODE_CLAMP = 2'd1;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPT = 3'd0,
        ST_REJECT = 3'd1,
        ST_RANGE  = 3'd2,
        ST_LIMIT  = 3'd3,
        ST_DONE   = 3'd4
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FIELD_WIDTH  = 3'd0,
        REG_FIELD_HEIGHT = 3'd1,
        REG_CELL_COUNT   = 3'd2,
        REG_DMIN_LOWER   = 3'd3,
        REG_DMIN_UPPER   = 3'd4,
        REG_DRAW_MODE    = 3'd5,
        REG_REJECT_LIMIT = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic done;
        logic found;
    } scan_stat_t;

    typedef struct packed {
        status_t                  status;
        logic [CIDX_W-1:0]        cell_index;
        logic [COORD_W-1:0]       cand_x;
        logic [COORD_W-1:0]       cand_y;
        logic signed [DIST_W-1:0] cell_dist;
        logic [REJ_W-1:0]         cell_rejects;
        logic [NIDX_W-1:0]        nearest_index;
        logic [DSQ_W-1:0]         nearest_dist_sq;
    } result_t;

endpackage

FILE: src/sequential_dmin_point_placement.sv
// Top level of the sequential minimum-distance point placement block.
//
// Input stream (s_*): one transfer is one trial, carrying two uniform
// fractions and a minimum-distance draw. Output stream (m_*): one transfer
// per input transfer, the trial result, with the status code in m_tuser.
// Configuration: cfg_we writes cfg_data to register cfg_index;
// write only while the block is idle.
//
// A trial passes from the input registers through CHECK, the scan over the
// N points placed so far and EMIT into the output register; the nearest-point
// scan reads the point store once per cycle. Trials that end early (error,
// done, draw out of range) skip the scan and go from CHECK to EMIT.
// One trial is in work at a time; s_tready is high only between trials.
//
// Reset clears the placed count, reject counters, draw latch and error flag
// and loads the register defaults; the point store needs no clearing.
// A finished result waits in the output register while m_tready is low; the
// next trial may be taken meanwhile but its result holds until that transfer.
module sequential_dmin_point_placement #(
    parameter int MAX_CELLS = sdpp_pkg::MAX_CELLS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // frac_x[15:0], frac_y[31:16], dist_draw[48:32]
    input  logic [sdpp_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // cell_index[9:0], cand_x[25:10], cand_y[41:26], cell_dist[58:42],
    // cell_rejects[78:59], nearest_index[89:79], nearest_dist_sq[122:90]
    output logic [sdpp_pkg::OUT_DATA_W-1:0]   m_tdata,
    // status[2:0]
    output logic [sdpp_pkg::STATUS_W-1:0]     m_tuser,
    input  logic                              cfg_we,
    input  logic [sdpp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sdpp_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import sdpp_pkg::*;

    localparam int IDX_W = $clog2(MAX_CELLS);
    localparam int CNT_W = $clog2(MAX_CELLS + 1);
    localparam int CMP_W = (CNT_W > CELLS_W) ? CNT_W : CELLS_W;

    typedef enum logic [2:0] {
        IDLE,
        CHECK,
        SCAN,
        EMIT
    } state_t;

    state_t state_reg;

    logic [COORD_W-1:0]       field_width_reg;
    logic [COORD_W-1:0]       field_height_reg;
    logic [CELLS_W-1:0]       cell_count_reg;
    logic signed [DIST_W-1:0] dmin_lower_reg;
    logic signed [DIST_W-1:0] dmin_upper_reg;
    logic [1:0]               draw_mode_reg;
    logic [REJ_W-1:0]         reject_limit_reg;

    logic [COORD_W-1:0]       frac_x_reg;
    logic [COORD_W-1:0]       frac_y_reg;
    logic signed [DIST_W-1:0] draw_reg;

    logic [CNT_W-1:0]         placed_count_reg;
    logic [REJ_W-1:0]         total_rejects_reg;
    logic [REJ_W-1:0]         cell_rejects_reg;
    logic signed [DIST_W-1:0] latched_dist_reg;
    logic                     latch_valid_reg;
    logic                     error_flag_reg;

    logic [COORD_W-1:0]       cx_reg;
    logic [COORD_W-1:0]       cy_reg;
    logic signed [DIST_W-1:0] d_reg;
    logic [PROD_W-1:0]        need_reg;
    logic                     scan_start_reg;

    result_t                  res_reg;
    result_t                  out_reg;
    logic                     m_tvalid_reg;

    scan_stat_t               scan_stat;
    logic [DSQ_W-1:0]         scan_best;
    logic [IDX_W-1:0]         scan_best_idx;
    logic [IDX_W-1:0]         ram_raddr;
    logic [PROD_W-1:0]        ram_rdata;

    logic                     run_done;
    logic                     range_ok;
    logic signed [DIST_W-1:0] d_sel;
    logic                     d_sel_pos;
    logic [PROD_W-1:0]        prod_x;
    logic [PROD_W-1:0]        prod_y;
    logic                     reject;
    logic                     limit_hit;
    logic [REJ_W-1:0]         total_inc;
    logic [REJ_W-1:0]         cell_inc;
    logic [NIDX_W-1:0]        nearest_out;
    logic                     ram_we;
    logic                     chk_go;
    result_t                  chk_res;
    result_t                  scan_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_width_reg  <= 16'd65535;
            field_height_reg <= 16'd65535;
            cell_count_reg   <= 11'd1024;
            dmin_lower_reg   <= 17'sd0;
            dmin_upper_reg   <= 17'sd65535;
            draw_mode_reg    <= MODE_LATCH;
            reject_limit_reg <= 20'd999999;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FIELD_WIDTH:  field_width_reg  <= cfg_data[COORD_W-1:0];
                REG_FIELD_HEIGHT: field_height_reg <= cfg_data[COORD_W-1:0];
                REG_CELL_COUNT:   cell_count_reg   <= cfg_data[CELLS_W-1:0];
                REG_DMIN_LOWER:   dmin_lower_reg   <= $signed(cfg_data[DIST_W-1:0]);
                REG_DMIN_UPPER:   dmin_upper_reg   <= $signed(cfg_data[DIST_W-1:0]);
                REG_DRAW_MODE:    draw_mode_reg    <= cfg_data[1:0];
                REG_REJECT_LIMIT: reject_limit_reg <= cfg_data[REJ_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        run_done = (CMP_W'(placed_count_reg) >= CMP_W'(MAX_CELLS))
                || (CMP_W'(placed_count_reg) >= CMP_W'(cell_count_reg));
        range_ok = (draw_reg > dmin_lower_reg) && (draw_reg < dmin_upper_reg);

        case (draw_mode_reg)
            MODE_LATCH: d_sel = latch_valid_reg ? latched_dist_reg : draw_reg;
            MODE_CLAMP: d_sel = draw_reg[DIST_W-1] ? '0 : draw_reg;
            default:    d_sel = draw_reg;
        endcase
        d_sel_pos = !d_sel[DIST_W-1] && (d_sel != '0);

        prod_x = frac_x_reg * field_width_reg;
        prod_y = frac_y_reg * field_height_reg;

        reject = !d_reg[DIST_W-1] && (d_reg != '0) && scan_stat.found
              && (scan_best < DSQ_W'(need_reg));
        total_inc = (total_rejects_reg == REJ_MAX) ? total_rejects_reg
                                                   : total_rejects_reg + REJ_W'(1);
        cell_inc  = (cell_rejects_reg == REJ_MAX) ? cell_rejects_reg
                                                  : cell_rejects_reg + REJ_W'(1);
        limit_hit = total_inc > reject_limit_reg;
        nearest_out = scan_stat.found ? NIDX_W'(scan_best_idx) : '1;
        ram_we = (state_reg == SCAN) && scan_stat.done && !reject;

        chk_go                = 1'b0;
        chk_res               = '0;
        chk_res.cell_index    = CIDX_W'(placed_count_reg);
        chk_res.cell_rejects  = cell_rejects_reg;
        chk_res.nearest_index = '1;
        if (error_flag_reg)
        begin
            chk_res.status = ST_LIMIT;
        end
        else if (run_done)
        begin
            chk_res               = '0;
            chk_res.status        = ST_DONE;
            chk_res.nearest_index = '1;
        end
        else if (draw_mode_reg[1] && !range_ok)
        begin
            chk_res.status    = ST_RANGE;
            chk_res.cell_dist = draw_reg;
        end
        else
        begin
            chk_go = 1'b1;
        end

        scan_res.status          = reject ? (limit_hit ? ST_LIMIT : ST_REJECT) : ST_ACCEPT;
        scan_res.cell_index      = CIDX_W'(placed_count_reg);
        scan_res.cand_x          = cx_reg;
        scan_res.cand_y          = cy_reg;
        scan_res.cell_dist       = d_reg;
        scan_res.cell_rejects    = reject ? cell_inc : cell_rejects_reg;
        scan_res.nearest_index   = nearest_out;
        scan_res.nearest_dist_sq = scan_best;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= IDLE;
            frac_x_reg        <= '0;
            frac_y_reg        <= '0;
            draw_reg          <= '0;
            placed_count_reg  <= '0;
            total_rejects_reg <= '0;
            cell_rejects_reg  <= '0;
            latched_dist_reg  <= '0;
            latch_valid_reg   <= 1'b0;
            error_flag_reg    <= 1'b0;
            cx_reg            <= '0;
            cy_reg            <= '0;
            d_reg             <= '0;
            need_reg          <= '0;
            scan_start_reg    <= 1'b0;
            res_reg           <= '0;
            out_reg           <= '0;
            m_tvalid_reg      <= 1'b0;
        end
        else
        begin
            scan_start_reg <= (state_reg == CHECK) && chk_go;
            if (m_tvalid_reg && m_tready && state_reg != EMIT)
            begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                IDLE:
                begin
                    if (s_tvalid)
                    begin
                        frac_x_reg <= s_tdata[COORD_W-1:0];
                        frac_y_reg <= s_tdata[2*COORD_W-1:COORD_W];
                        draw_reg   <= $signed(s_tdata[2*COORD_W +: DIST_W]);
                        state_reg  <= CHECK;
                    end
                end

                CHECK:
                begin
                    res_reg <= chk_res;
                    if (chk_go)
                    begin
                        if (draw_mode_reg == MODE_LATCH && !latch_valid_reg)
                        begin
                            latched_dist_reg <= draw_reg;
                            latch_valid_reg  <= 1'b1;
                        end
                        cx_reg    <= prod_x[COORD_BITS +: COORD_W];
                        cy_reg    <= prod_y[COORD_BITS +: COORD_W];
                        d_reg     <= d_sel;
                        need_reg  <= d_sel_pos ? d_sel[COORD_W-1:0] * d_sel[COORD_W-1:0]
                                               : '0;
                        state_reg <= SCAN;
                    end
                    else
                    begin
                        state_reg <= EMIT;
                    end
                end

                SCAN:
                begin
                    if (scan_stat.done)
                    begin
                        res_reg <= scan_res;
                        if (reject)
                        begin
                            total_rejects_reg <= total_inc;
                            cell_rejects_reg  <= cell_inc;
                            if (limit_hit)
                            begin
                                error_flag_reg <= 1'b1;
                            end
                        end
                        else
                        begin
                            placed_count_reg <= placed_count_reg + CNT_W'(1);
                            cell_rejects_reg <= '0;
                            latch_valid_reg  <= 1'b0;
                        end
                        state_reg <= EMIT;
                    end
                end

                EMIT:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        out_reg      <= res_reg;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= IDLE;
                    end
                end

                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    sdpp_ram #(
        .WIDTH (PROD_W),
        .DEPTH (MAX_CELLS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (placed_count_reg[IDX_W-1:0]),
        .wdata ({cy_reg, cx_reg}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sdpp_scan #(
        .MAX_CELLS (MAX_CELLS)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (scan_start_reg),
        .count    (placed_count_reg),
        .cand_x   (cx_reg),
        .cand_y   (cy_reg),
        .raddr    (ram_raddr),
        .rdata    (ram_rdata),
        .stat     (scan_stat),
        .best     (scan_best),
        .best_idx (scan_best_idx)
    );

    assign s_tready = (state_reg == IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {{OUT_PAD_W{1'b0}},
                       out_reg.nearest_dist_sq,
                       out_reg.nearest_index,
                       out_reg.cell_rejects,
                       out_reg.cell_dist,
                       out_reg.cand_y,
                       out_reg.cand_x,
                       out_reg.cell_index};

    assert property (@(posedge clk) disable iff (!rst_n)
        scan_stat.done |-> state_reg == SCAN)
        else $error("scan finished outside of a trial");

    assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(placed_count_reg) <= CMP_W'(MAX_CELLS))
        else $error("placed count beyond store depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        error_flag_reg |=> error_flag_reg)
        else $error("error flag dropped");

    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg == CHECK && !scan_start_reg)
        else $error("accepted trial did not enter check");

endmodule

FILE: src/sdpp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sdpp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/sdpp_scan.sv
// Nearest-point scan: one stored point per cycle through a pipelined squared-distance unit.
module sdpp_scan #(
    parameter int MAX_CELLS = 1024,
    localparam int IDX_W    = $clog2(MAX_CELLS),
    localparam int CNT_W    = $clog2(MAX_CELLS + 1)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [CNT_W-1:0]               count,
    input  logic [sdpp_pkg::COORD_W-1:0]   cand_x,
    input  logic [sdpp_pkg::COORD_W-1:0]   cand_y,
    output logic [IDX_W-1:0]               raddr,
    input  logic [2*sdpp_pkg::COORD_W-1:0] rdata,
    output sdpp_pkg::scan_stat_t           stat,
    output logic [sdpp_pkg::DSQ_W-1:0]     best,
    output logic [IDX_W-1:0]               best_idx
);

    import sdpp_pkg::*;

    logic               busy_reg;
    logic               issue_reg;
    logic [CNT_W-1:0]   addr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               rd_v_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic               a_v_reg;
    logic [IDX_W-1:0]   a_idx_reg;
    logic [COORD_W-1:0] dx_reg;
    logic [COORD_W-1:0] dy_reg;
    logic               b_v_reg;
    logic [IDX_W-1:0]   b_idx_reg;
    logic [PROD_W-1:0]  sqx_reg;
    logic [PROD_W-1:0]  sqy_reg;
    logic               found_reg;
    logic [DSQ_W-1:0]   best_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic               done_reg;

    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [DSQ_W-1:0]   sum;
    logic [CNT_W-1:0]   addr_inc;
    logic               finish;

    assign px       = rdata[COORD_W-1:0];
    assign py       = rdata[2*COORD_W-1:COORD_W];
    assign sum      = DSQ_W'(sqx_reg) + DSQ_W'(sqy_reg);
    assign addr_inc = addr_reg + CNT_W'(1);
    assign raddr    = addr_reg[IDX_W-1:0];
    assign finish   = busy_reg && !issue_reg && !rd_v_reg && !a_v_reg && !b_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            issue_reg    <= 1'b0;
            addr_reg     <= '0;
            count_reg    <= '0;
            rd_v_reg     <= 1'b0;
            rd_idx_reg   <= '0;
            a_v_reg      <= 1'b0;
            a_idx_reg    <= '0;
            dx_reg       <= '0;
            dy_reg       <= '0;
            b_v_reg      <= 1'b0;
            b_idx_reg    <= '0;
            sqx_reg      <= '0;
            sqy_reg      <= '0;
            found_reg    <= 1'b0;
            best_reg     <= EMPTY_DSQ;
            best_idx_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= !start && finish;

            rd_v_reg   <= issue_reg;
            rd_idx_reg <= addr_reg[IDX_W-1:0];

            a_v_reg   <= rd_v_reg;
            a_idx_reg <= rd_idx_reg;
            dx_reg    <= (px > cand_x) ? px - cand_x : cand_x - px;
            dy_reg    <= (py > cand_y) ? py - cand_y : cand_y - py;

            b_v_reg   <= a_v_reg;
            b_idx_reg <= a_idx_reg;
            sqx_reg   <= dx_reg * dx_reg;
            sqy_reg   <= dy_reg * dy_reg;

            if (start)
            begin
                busy_reg     <= 1'b1;
                issue_reg    <= (count != '0);
                addr_reg     <= '0;
                count_reg    <= count;
                found_reg    <= 1'b0;
                best_reg     <= EMPTY_DSQ;
                best_idx_reg <= '0;
            end
            else
            begin
                if (issue_reg)
                begin
                    addr_reg <= addr_inc;
                    if (addr_inc == count_reg)
                    begin
                        issue_reg <= 1'b0;
                    end
                end

                if (b_v_reg && (!found_reg || sum < best_reg))
                begin
                    found_reg    <= 1'b1;
                    best_reg     <= sum;
                    best_idx_reg <= b_idx_reg;
                end

                if (finish)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign stat.done  = done_reg;
    assign stat.found = found_reg;
    assign best       = best_reg;
    assign best_idx   = best_idx_reg;

endmodule

FILE: sim/tb_sequential_dmin_point_placement.sv
// Testbench for sequential_dmin_point_placement: queued trials, self-checking placement predictor.
`timescale 1ns / 100ps

module tb_sequential_dmin_point_placement;

    import sdpp_pkg::*;

    localparam int          CLK_HALF    = 6;
    localparam int          CELL_CAP    = MAX_CELLS_DEF;
    localparam int          HOLD_CYCLES = 2500;
    localparam int unsigned CYCLE_LIMIT = 4000000;
    localparam logic [32:0] NO_POINT_DSQ = 33'h1_FFFC_0002;
    localparam logic [1:0]  MODE_RANGED     = 2'd2;
    localparam logic [1:0]  MODE_RANGED_ALT = 2'd3;

    typedef struct packed {
        logic signed [DIST_W-1:0] draw;
        logic [COORD_W-1:0]       fy;
        logic [COORD_W-1:0]       fx;
    } trial_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]   m_tuser;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // register shadow
    logic [15:0]        cf_width  = 16'hFFFF;
    logic [15:0]        cf_height = 16'hFFFF;
    logic [10:0]        cf_cells  = 11'd1024;
    logic signed [16:0] cf_lo     = 17'sd0;
    logic signed [16:0] cf_hi     = 17'sd65535;
    logic [1:0]         cf_mode   = MODE_LATCH;
    logic [19:0]        cf_limit  = 20'd999999;

    // placement state
    logic [15:0]        store_x [CELL_CAP];
    logic [15:0]        store_y [CELL_CAP];
    logic [10:0]        pl_count  = '0;
    logic [19:0]        tot_rej   = '0;
    logic [19:0]        cell_rej  = '0;
    logic signed [16:0] lat_dist  = '0;
    logic               lat_ok    = 1'b0;
    logic               err_flag  = 1'b0;

    trial_t      trial_q [$];
    result_t     outcome_q [$];
    trial_t      cur_trial = '0;
    int          src_idle  = 25;
    int          snk_idle  = 25;
    int          mism      = 0;
    int unsigned cycles    = 0;
    logic        hold_arm  = 1'b0;
    logic        hold_on   = 1'b0;

    sequential_dmin_point_placement dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    function automatic result_t place_trial(trial_t t);
        result_t            r;
        logic [10:0]        target;
        logic signed [16:0] d;
        logic [16:0]        du;
        logic [31:0]        prod_x;
        logic [31:0]        prod_y;
        logic [15:0]        cx;
        logic [15:0]        cy;
        logic [15:0]        dx;
        logic [15:0]        dy;
        logic [32:0]        best;
        logic [32:0]        s;
        logic [32:0]        need;
        int                 bi;
        r = '0;
        r.nearest_index = '1;
        target = (cf_cells < 11'(CELL_CAP)) ? cf_cells : 11'(CELL_CAP);
        if (err_flag)
        begin
            r.status       = ST_LIMIT;
            r.cell_index   = pl_count[9:0];
            r.cell_rejects = cell_rej;
            return r;
        end
        if (pl_count >= target)
        begin
            r.status = ST_DONE;
            return r;
        end
        if (cf_mode == MODE_LATCH)
        begin
            if (!lat_ok)
            begin
                lat_dist = t.draw;
                lat_ok   = 1'b1;
            end
            d = lat_dist;
        end
        else if (cf_mode == MODE_CLAMP)
            d = (t.draw < 0) ? 17'sd0 : t.draw;
        else
        begin
            if (!(t.draw > cf_lo && t.draw < cf_hi))
            begin
                r.status       = ST_RANGE;
                r.cell_index   = pl_count[9:0];
                r.cell_dist    = t.draw;
                r.cell_rejects = cell_rej;
                return r;
            end
            d = t.draw;
        end
        prod_x = {16'b0, t.fx} * {16'b0, cf_width};
        prod_y = {16'b0, t.fy} * {16'b0, cf_height};
        cx = prod_x[31:16];
        cy = prod_y[31:16];
        best = NO_POINT_DSQ;
        bi = -1;
        for (int i = 0; i < int'(pl_count); i++)
        begin
            dx = (store_x[i] > cx) ? store_x[i] - cx : cx - store_x[i];
            dy = (store_y[i] > cy) ? store_y[i] - cy : cy - store_y[i];
            s = 33'(dx) * 33'(dx) + 33'(dy) * 33'(dy);
            if (bi < 0 || s < best)
            begin
                best = s;
                bi   = i;
            end
        end
        du = d;
        need = (d > 0) ? 33'(du) * 33'(du) : 33'd0;
        r.cell_index      = pl_count[9:0];
        r.cand_x          = cx;
        r.cand_y          = cy;
        r.cell_dist       = d;
        r.nearest_index   = 11'(bi);
        r.nearest_dist_sq = best;
        if (d > 0 && bi >= 0 && best < need)
        begin
            if (tot_rej != '1)
                tot_rej++;
            if (cell_rej != '1)
                cell_rej++;
            r.cell_rejects = cell_rej;
            if (tot_rej > cf_limit)
            begin
                err_flag = 1'b1;
                r.status = ST_LIMIT;
            end
            else
                r.status = ST_REJECT;
            return r;
        end
        r.status       = ST_ACCEPT;
        r.cell_rejects = cell_rej;
        store_x[pl_count % CELL_CAP] = cx;
        store_y[pl_count % CELL_CAP] = cy;
        pl_count++;
        cell_rej = '0;
        lat_ok   = 1'b0;
        return r;
    endfunction

    function automatic void check_field(string name, logic [32:0] want, logic [32:0] got);
        if (want !== got)
        begin
            mism++;
            if (mism <= 10)
                $display("mismatch %s at cycle %0d: expected %0h, got %0h",
                         name, cycles, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : sender
        trial_t nxt;
        logic   offer;
        if (!rst_n)
        begin
            s_tvalid  <= 1'b0;
            s_tdata   <= '0;
            cur_trial <= '0;
        end
        else
        begin
            offer = s_tvalid;
            nxt   = cur_trial;
            if (s_tvalid && s_tready)
            begin
                outcome_q.push_back(place_trial(cur_trial));
                offer = 1'b0;
            end
            if (!offer && trial_q.size() > 0 && $urandom_range(0, 99) >= src_idle)
            begin
                nxt   = trial_q.pop_front();
                offer = 1'b1;
            end
            cur_trial <= nxt;
            s_tvalid  <= offer;
            s_tdata   <= {7'b0, nxt.draw, nxt.fy, nxt.fx};
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : receiver
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= !hold_on && ($urandom_range(0, 99) >= snk_idle);
    end

    initial
    begin : receiver_hold
        wait (hold_arm);
        @(posedge clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
    end

    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status          = status_t'(m_tuser);
            got.cell_index      = m_tdata[9:0];
            got.cand_x          = m_tdata[25:10];
            got.cand_y          = m_tdata[41:26];
            got.cell_dist       = m_tdata[58:42];
            got.cell_rejects    = m_tdata[78:59];
            got.nearest_index   = m_tdata[89:79];
            got.nearest_dist_sq = m_tdata[122:90];
            if (outcome_q.size() == 0)
            begin
                mism++;
                if (mism <= 10)
                    $display("unexpected transfer at cycle %0d, status %0d", cycles, m_tuser);
            end
            else
            begin
                want = outcome_q.pop_front();
                check_field("status", want.status, got.status);
                check_field("cell_index", want.cell_index, got.cell_index);
                check_field("cand_x", want.cand_x, got.cand_x);
                check_field("cand_y", want.cand_y, got.cand_y);
                check_field("cell_dist", want.cell_dist, got.cell_dist);
                check_field("cell_rejects", want.cell_rejects, got.cell_rejects);
                check_field("nearest_index", want.nearest_index, got.nearest_index);
                check_field("nearest_dist_sq", want.nearest_dist_sq, got.nearest_dist_sq);
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_reg(reg_index_t idx, int val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 20'(val);
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_FIELD_WIDTH:  cf_width  = 16'(val);
            REG_FIELD_HEIGHT: cf_height = 16'(val);
            REG_CELL_COUNT:   cf_cells  = 11'(val);
            REG_DMIN_LOWER:   cf_lo     = 17'(val);
            REG_DMIN_UPPER:   cf_hi     = 17'(val);
            REG_DRAW_MODE:    cf_mode   = 2'(val);
            REG_REJECT_LIMIT: cf_limit  = 20'(val);
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (trial_q.size() > 0 || outcome_q.size() > 0 || s_tvalid)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic queue_trial(int fx, int fy, int draw);
        trial_t t;
        t.fx   = 16'(fx);
        t.fy   = 16'(fy);
        t.draw = 17'(draw);
        trial_q.push_back(t);
    endtask

    task automatic run_phase(int count, int dscale);
        trial_t t;
        for (int i = 0; i < count; i++)
        begin
            t.fx = 16'($urandom);
            t.fy = 16'($urandom);
            case ($urandom_range(0, 7))
                0:       t.draw = 17'($urandom);
                1:       t.draw = 17'(-int'($urandom_range(0, dscale)));
                default: t.draw = 17'($urandom_range(0, dscale));
            endcase
            trial_q.push_back(t);
        end
        wait_idle();
    endtask

    initial
    begin : stimulus
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // latched draw per cell, empty store, tie on nearest
        queue_trial(16'h0000, 16'h0000, 100);
        queue_trial(16'hFFFF, 16'hFFFF, 5);
        queue_trial(16'h0000, 16'h0000, 20);
        queue_trial(16'h0001, 16'h0001, -5);
        queue_trial(16'h8000, 16'h8000, 20);
        wait_idle();

        // clamped draw, boundary of equal distance
        write_reg(REG_DRAW_MODE, MODE_CLAMP);
        queue_trial(4, 5, 6);
        queue_trial(4, 5, 5);
        queue_trial(16'h0000, 16'h0000, -65536);
        queue_trial(16'hFFFF, 16'h0000, 65535);
        wait_idle();

        // ranged draws at and inside the bounds
        write_reg(REG_DMIN_LOWER, -10);
        write_reg(REG_DMIN_UPPER, 10);
        write_reg(REG_DRAW_MODE, MODE_RANGED);
        queue_trial(16'h1234, 16'h4321, -10);
        queue_trial(16'h1234, 16'h4321, 10);
        queue_trial(16'h4000, 16'hC000, 9);
        queue_trial(16'hC000, 16'h4000, -9);
        wait_idle();

        write_reg(REG_DMIN_LOWER, -65536);
        write_reg(REG_DMIN_UPPER, 65535);
        write_reg(REG_DRAW_MODE, MODE_RANGED_ALT);
        queue_trial(16'hA5A5, 16'h5A5A, -65536);
        queue_trial(16'h5A5A, 16'hA5A5, 65535);
        queue_trial(16'h7FFF, 16'h0001, -65535);
        wait_idle();

        // unit field collapses every candidate onto the origin
        write_reg(REG_FIELD_WIDTH, 1);
        write_reg(REG_FIELD_HEIGHT, 1);
        write_reg(REG_DRAW_MODE, MODE_CLAMP);
        queue_trial(16'hFFFF, 16'hFFFF, 0);
        queue_trial(16'h1234, 16'h5678, 1);
        wait_idle();

        write_reg(REG_CELL_COUNT, int'(pl_count));
        write_reg(REG_REJECT_LIMIT, 0);
        queue_trial(16'h0F0F, 16'hF0F0, 300);
        wait_idle();
        write_reg(REG_CELL_COUNT, 0);
        queue_trial(16'hF0F0, 16'h0F0F, -300);
        wait_idle();

        write_reg(REG_CELL_COUNT, 2047);
        write_reg(REG_REJECT_LIMIT, 1048575);
        write_reg(REG_FIELD_WIDTH, 65535);
        write_reg(REG_FIELD_HEIGHT, 65535);
        write_reg(REG_DRAW_MODE, MODE_LATCH);
        hold_arm = 1'b1;
        run_phase(100, 6000);

        src_idle = 0;
        snk_idle = 0;
        write_reg(REG_FIELD_WIDTH, 40000);
        write_reg(REG_FIELD_HEIGHT, 20000);
        write_reg(REG_DRAW_MODE, MODE_CLAMP);
        run_phase(100, 4000);
        src_idle = 25;
        snk_idle = 25;

        write_reg(REG_FIELD_WIDTH, 65535);
        write_reg(REG_FIELD_HEIGHT, 65535);
        write_reg(REG_DMIN_LOWER, -3000);
        write_reg(REG_DMIN_UPPER, 5000);
        write_reg(REG_DRAW_MODE, MODE_RANGED);
        run_phase(100, 8000);

        write_reg(REG_FIELD_WIDTH, 257);
        write_reg(REG_FIELD_HEIGHT, 129);
        write_reg(REG_DRAW_MODE, MODE_CLAMP);
        run_phase(80, 40);

        write_reg(REG_FIELD_WIDTH, 65535);
        write_reg(REG_FIELD_HEIGHT, 1000);
        write_reg(REG_REJECT_LIMIT, 999999);
        write_reg(REG_DRAW_MODE, MODE_LATCH);
        run_phase(100, 3000);

        write_reg(REG_FIELD_HEIGHT, 65535);
        write_reg(REG_DMIN_LOWER, 0);
        write_reg(REG_DMIN_UPPER, 65535);
        write_reg(REG_DRAW_MODE, MODE_RANGED_ALT);
        run_phase(80, 10000);

        // drive the reject total past its limit, then hold the error state
        write_reg(REG_FIELD_WIDTH, 1);
        write_reg(REG_FIELD_HEIGHT, 1);
        write_reg(REG_DRAW_MODE, MODE_CLAMP);
        write_reg(REG_REJECT_LIMIT, int'(tot_rej) + 3);
        for (int i = 0; i < 8; i++)
            queue_trial($urandom, $urandom, $urandom_range(1, 65535));
        wait_idle();
        write_reg(REG_CELL_COUNT, 0);
        queue_trial($urandom, $urandom, $urandom);
        queue_trial($urandom, $urandom, $urandom);
        wait_idle();

        repeat (64) @(posedge clk);
        if (mism == 0 && outcome_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
